FILE: hdl/tcfe_pkg.sv
// shared constants, types and helper functions for the calendar field extractor
package tcfe_pkg;

  localparam int MillisW = 49;
  localparam int ModeW   = 4;
  localparam int FieldW  = 39;
  localparam int SecW    = 40;
  localparam int DayW    = 23;
  localparam int SodW    = 17;

  localparam int MilliDiv  = 1000;
  localparam int DaySecs   = 86400;
  localparam int EraDays   = 146097;
  localparam int Recip1460 = 183861;
  localparam int Recip365  = 735440;
  localparam int YearShift = 10000;

  // 25 eras of bias keep the day count positive; 3652425 is a multiple of 7
  localparam logic [SecW-1:0] SecBias    = 40'd315569520000;
  localparam logic [DayW-1:0] CivilShift = 23'd719468;

  typedef enum logic [ModeW-1:0] {
    MODE_MILLENNIUM = 4'd0,
    MODE_CENTURY    = 4'd1,
    MODE_DECADE     = 4'd2,
    MODE_YEAR       = 4'd3,
    MODE_DOY        = 4'd4,
    MODE_QUARTER    = 4'd5,
    MODE_MONTH      = 4'd6,
    MODE_ISOWEEK    = 4'd7,
    MODE_DOW        = 4'd8,
    MODE_DAY        = 4'd9,
    MODE_HOUR       = 4'd10,
    MODE_MINUTE     = 4'd11,
    MODE_SECOND     = 4'd12,
    MODE_EPOCHSEC   = 4'd13
  } mode_t;

  typedef struct packed {
    logic [3:0]  q;
    logic [23:0] r;
  } div_step_t;

  typedef struct packed {
    logic              valid;
    logic [DayW-1:0]   days;
    logic [SodW-1:0]   sod;
    logic [FieldW-1:0] secs;
    logic [ModeW-1:0]  mode;
  } tcfe_split_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [FieldW-1:0] secs;
    logic [2:0]        wday;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } tcfe_tag_t;

  // one radix-16 digit of a division by a constant
  function automatic div_step_t div_step(input logic [23:0] r, input logic [3:0] nib,
                                         input logic [23:0] d);
    logic [31:0] acc;
    div_step_t   res;
    acc   = {4'd0, r, nib};
    res.q = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (acc >= 32'(k) * {8'd0, d}) res.q = 4'(k);
    end
    acc   = acc - {28'd0, res.q} * {8'd0, d};
    res.r = acc[23:0];
    return res;
  endfunction

  // residue mod 7 by octal digit sums
  function automatic logic [2:0] mod7(input logic [23:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 6'd0;
    for (int k = 0; k < 8; k++) s1 = s1 + 6'(x[3*k +: 3]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 3'(s2[3]) + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

  function automatic logic [5:0] era_of(input logic [DayW-1:0] z);
    logic [5:0] e;
    e = 6'd0;
    for (int k = 1; k < 53; k++) begin
      if (z >= DayW'(k * EraDays)) e = 6'(k);
    end
    return e;
  endfunction

  function automatic logic [4:0] hour_of(input logic [SodW-1:0] s);
    logic [4:0] h;
    h = 5'd0;
    for (int k = 1; k < 24; k++) begin
      if (s >= SodW'(k * 3600)) h = 5'(k);
    end
    return h;
  endfunction

  function automatic logic [5:0] min_of(input logic [11:0] s);
    logic [5:0] m;
    m = 6'd0;
    for (int k = 1; k < 60; k++) begin
      if (s >= 12'(k * 60)) m = 6'(k);
    end
    return m;
  endfunction

  function automatic logic [2:0] c36_of(input logic [17:0] doe);
    logic [2:0] c;
    c = 3'd0;
    for (int k = 1; k < 5; k++) begin
      if (doe >= 18'(k * 36524)) c = 3'(k);
    end
    return c;
  endfunction

  function automatic logic [1:0] cent_of(input logic [8:0] yoe);
    logic [1:0] c;
    c = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (yoe >= 9'(k * 100)) c = 2'(k);
    end
    return c;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] mp_of(input logic [8:0] dy);
    logic [3:0] m;
    m = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (dy >= month_start(4'(k))) m = 4'(k);
    end
    return m;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // leap rule on a year offset within its 400-year cycle, offset below 800
  function automatic logic is_leap(input logic [9:0] x);
    logic [9:0] xm;
    xm = (x >= 10'd400) ? x - 10'd400 : x;
    return (xm[1:0] == 2'd0) && (xm != 10'd100) && (xm != 10'd200) && (xm != 10'd300);
  endfunction

  function automatic logic [2:0] quarter_of(input logic [3:0] mon);
    logic [2:0] q;
    if (mon <= 4'd3) q = 3'd1;
    else if (mon <= 4'd6) q = 3'd2;
    else if (mon <= 4'd9) q = 3'd3;
    else q = 3'd4;
    return q;
  endfunction

endpackage

FILE: hdl/tcfe_stamp_if.sv
// timestamp input channel
interface tcfe_stamp_if;
  logic               valid;
  logic               ready;
  logic signed [48:0] epoch_millis;
  logic [3:0]         mode;

  modport source (output valid, output epoch_millis, output mode, input ready);
  modport sink   (input valid, input epoch_millis, input mode, output ready);
endinterface

FILE: hdl/tcfe_field_if.sv
// calendar field result channel
interface tcfe_field_if;
  logic               valid;
  logic               ready;
  logic signed [38:0] field_value;

  modport source (output valid, output field_value, input ready);
  modport sink   (input valid, input field_value, output ready);
endinterface

FILE: hdl/timestamp_calendar_field_extract_unit.sv
// top level of the timestamp calendar field extractor
//
// stamp channel: one transfer carries a signed millisecond count since
// 1970-01-01 UTC and a mode code; field channel: one transfer carries the
// selected calendar field as a 39-bit two's complement value.
// every stamp transfer yields exactly one field transfer, in order.
// the result passes 36 register stages before it shows on the field channel;
// throughput is one item per cycle while no result waits on an idle receiver.
// the 36 stages are an input register and 13 radix-16 digit steps dividing by 1000,
// a register and 10 digit steps dividing by 86400, and 11 stages of civil date,
// time and select logic.
// the whole pipeline advances together: while a result waits on an idle
// receiver, stamp ready drops and every stage holds, bubbles included, so
// nothing is lost or repeated and no stage fills in behind the held result.
// synchronous reset clears every stage valid bit; data registers are not reset.
module timestamp_calendar_field_extract_unit
  import tcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tcfe_stamp_if.sink  stamp,
  tcfe_field_if.source field
);

  logic        en;
  tcfe_split_t split_res;
  logic [FieldW-1:0] value;

  assign en          = !field.valid || field.ready;
  assign stamp.ready = en;

  tcfe_split u_split (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (stamp.valid),
    .epoch_millis (stamp.epoch_millis),
    .mode         (stamp.mode),
    .res          (split_res)
  );

  tcfe_civil u_civil (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .din         (split_res),
    .out_valid   (field.valid),
    .field_value (value)
  );

  assign field.field_value = $signed(value);

endmodule

FILE: hdl/tcfe_split.sv
// seconds truncation and day / second-of-day split, radix-16 digit pipelines
module tcfe_split
  import tcfe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [MillisW-1:0] epoch_millis,
  input  logic [ModeW-1:0]          mode,
  output tcfe_split_t               res
);

  localparam int ANib   = 13;
  localparam int AWorkW = ANib * 4;
  localparam int ARemW  = 10;
  localparam int BNib   = SecW / 4;
  localparam int BWorkW = BNib * 4;

  logic [MillisW-1:0] mag;

  logic              a_v    [ANib+1];
  logic [AWorkW-1:0] a_quo  [ANib+1];
  logic              a_neg  [ANib+1];
  logic [ModeW-1:0]  a_mode [ANib+1];
  logic [AWorkW-1:0] a_work [ANib];
  logic [ARemW-1:0]  a_rem  [ANib];

  logic [SecW-1:0] mq;
  logic [SecW-1:0] sq;

  logic              b_v    [BNib+1];
  logic [BWorkW-1:0] b_quo  [BNib+1];
  logic [SodW-1:0]   b_rem  [BNib+1];
  logic [FieldW-1:0] b_secs [BNib+1];
  logic [ModeW-1:0]  b_mode [BNib+1];
  logic [BWorkW-1:0] b_work [BNib];

  assign mag = epoch_millis[MillisW-1] ? MillisW'(-epoch_millis) : epoch_millis;

  always_ff @(posedge clk) begin
    if (rst) a_v[0] <= 1'b0;
    else if (en) a_v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg[0]  <= epoch_millis[MillisW-1];
      a_work[0] <= AWorkW'(mag);
      a_rem[0]  <= '0;
      a_quo[0]  <= '0;
      a_mode[0] <= mode;
    end
  end

  for (genvar i = 0; i < ANib; i++) begin : g_a
    div_step_t st;
    assign st = div_step(24'(a_rem[i]), a_work[i][AWorkW-1 -: 4], 24'(MilliDiv));

    always_ff @(posedge clk) begin
      if (rst) a_v[i+1] <= 1'b0;
      else if (en) a_v[i+1] <= a_v[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_quo[i+1]  <= {a_quo[i][AWorkW-5:0], st.q};
        a_neg[i+1]  <= a_neg[i];
        a_mode[i+1] <= a_mode[i];
      end
    end

    if (i < ANib - 1) begin : g_w
      always_ff @(posedge clk) begin
        if (en) begin
          a_work[i+1] <= a_work[i] << 4;
          a_rem[i+1]  <= st.r[ARemW-1:0];
        end
      end
    end
  end

  // truncated seconds, then biased so the floor split sees a positive count
  assign mq = a_quo[ANib][SecW-1:0];
  assign sq = a_neg[ANib] ? (~mq + SecW'(1)) : mq;

  always_ff @(posedge clk) begin
    if (rst) b_v[0] <= 1'b0;
    else if (en) b_v[0] <= a_v[ANib];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_work[0] <= sq + SecBias;
      b_rem[0]  <= '0;
      b_quo[0]  <= '0;
      b_secs[0] <= sq[FieldW-1:0];
      b_mode[0] <= a_mode[ANib];
    end
  end

  for (genvar i = 0; i < BNib; i++) begin : g_b
    div_step_t st;
    assign st = div_step(24'(b_rem[i]), b_work[i][BWorkW-1 -: 4], 24'(DaySecs));

    always_ff @(posedge clk) begin
      if (rst) b_v[i+1] <= 1'b0;
      else if (en) b_v[i+1] <= b_v[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        b_quo[i+1]  <= {b_quo[i][BWorkW-5:0], st.q};
        b_rem[i+1]  <= st.r[SodW-1:0];
        b_secs[i+1] <= b_secs[i];
        b_mode[i+1] <= b_mode[i];
      end
    end

    if (i < BNib - 1) begin : g_w
      always_ff @(posedge clk) begin
        if (en) b_work[i+1] <= b_work[i] << 4;
      end
    end
  end

  assign res.valid = b_v[BNib];
  assign res.days  = b_quo[BNib][DayW-1:0];
  assign res.sod   = b_rem[BNib];
  assign res.secs  = b_secs[BNib];
  assign res.mode  = b_mode[BNib];

endmodule

FILE: hdl/tcfe_civil.sv
// civil date, time of day, iso week and field select pipeline
module tcfe_civil
  import tcfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tcfe_split_t       din,
  output logic              out_valid,
  output logic [FieldW-1:0] field_value
);

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  tcfe_tag_t t1, t2, t3, t4, t5, t6, t7, t8, t9, t10;

  logic [DayW-1:0] z1, z2;
  logic [SodW-1:0] sod1;
  logic [5:0]      era2, era3, era4, era5, era6, era7, era8;
  logic [11:0]     srem2;
  logic [17:0]     doe3, doe4, doe5, doe6;
  logic [35:0]     p1_4;
  logic [2:0]      c36_4;
  logic            c146_4;
  logic [17:0]     vv5;
  logic [37:0]     p2_6;
  logic [8:0]      yoe7, dy7;
  logic [3:0]      mon8, mon9, mon10;
  logic [4:0]      mday8, mday9, mday10;
  logic [8:0]      yadj8;
  logic [15:0]     y9, y10;
  logic            leap9, leapp9, leap10, leapp10;
  logic [8:0]      yday9, yday10;
  logic [2:0]      quarter9, quarter10;
  logic            sgnm10, sgn010;
  logic [27:0]     pmil10;
  logic [26:0]     pcen10;
  logic [29:0]     pdec10;
  logic [5:0]      wk10;
  logic [2:0]      j1_10;

  tcfe_tag_t   t1_next, t3_next;
  logic [5:0]  mn3;
  logic [8:0]  yoe_c;
  logic [3:0]  mp_c;
  logic        leap_c;
  logic [15:0] ym1_c;
  logic [13:0] am1_c, a0_c;
  logic [3:0]  iso_wd_c;
  logic [8:0]  wx_c;
  logic [16:0] wprod_c;
  logic        wy53_c, wp53_c;
  logic [2:0]  jprev_c;
  logic [5:0]  wk_c;
  logic [FieldW-1:0] milq_c, cenq_c, decq_c, sel_c;

  // stage 1: era input, weekday, hour
  always_comb begin
    t1_next        = '0;
    t1_next.mode   = din.mode;
    t1_next.secs   = din.secs;
    t1_next.wday   = mod7(24'(din.days) + 24'd4);
    t1_next.hour   = hour_of(din.sod);
  end

  // stage 3: minute and second
  assign mn3 = min_of(srem2);
  always_comb begin
    t3_next        = t2;
    t3_next.minute = mn3;
    t3_next.second = 6'(srem2 - 12'(mn3) * 12'd60);
  end

  assign yoe_c  = p2_6[36:28];
  assign mp_c   = mp_of(dy7);
  assign leap_c = is_leap(10'(yadj8));

  assign ym1_c    = y9 - 16'd1;
  assign am1_c    = 14'(ym1_c[15] ? (16'd0 - ym1_c) : ym1_c);
  assign a0_c     = 14'(y9[15] ? (16'd0 - y9) : y9);
  assign iso_wd_c = (t9.wday == 3'd0) ? 4'd7 : 4'(t9.wday);
  assign wx_c     = yday9 + 9'd10 - 9'(iso_wd_c);
  assign wprod_c  = 17'(wx_c) * 17'd293;

  assign wy53_c  = (j1_10 == 3'd4) || ((j1_10 == 3'd3) && leap10);
  assign jprev_c = mod7(24'(j1_10) + 24'd7 - (leapp10 ? 24'd2 : 24'd1));
  assign wp53_c  = (jprev_c == 3'd4) || ((jprev_c == 3'd3) && leapp10);
  always_comb begin
    if (wk10 == 6'd0) wk_c = wp53_c ? 6'd53 : 6'd52;
    else if (wk10 > (wy53_c ? 6'd53 : 6'd52)) wk_c = 6'd1;
    else wk_c = wk10;
  end

  assign milq_c = FieldW'(pmil10[27:23]);
  assign cenq_c = FieldW'(pcen10[26:19]);
  assign decq_c = FieldW'(pdec10[29:19]);

  always_comb begin
    case (t10.mode)
      MODE_MILLENNIUM: sel_c = sgnm10 ? (FieldW'(1) - milq_c) : (milq_c + FieldW'(1));
      MODE_CENTURY:    sel_c = sgnm10 ? (FieldW'(1) - cenq_c) : (cenq_c + FieldW'(1));
      MODE_DECADE:     sel_c = sgn010 ? (FieldW'(0) - decq_c) : decq_c;
      MODE_YEAR:       sel_c = FieldW'($signed(y10));
      MODE_DOY:        sel_c = FieldW'(yday10);
      MODE_QUARTER:    sel_c = FieldW'(quarter10);
      MODE_MONTH:      sel_c = FieldW'(mon10);
      MODE_ISOWEEK:    sel_c = FieldW'(wk_c);
      MODE_DOW:        sel_c = FieldW'(t10.wday) + FieldW'(1);
      MODE_DAY:        sel_c = FieldW'(mday10);
      MODE_HOUR:       sel_c = FieldW'(t10.hour);
      MODE_MINUTE:     sel_c = FieldW'(t10.minute);
      MODE_SECOND:     sel_c = FieldW'(t10.second);
      MODE_EPOCHSEC:   sel_c = t10.secs;
      default:         sel_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= din.valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9; out_valid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1   <= din.days + CivilShift;
      sod1 <= din.sod;
      t1   <= t1_next;

      z2    <= z1;
      era2  <= era_of(z1);
      srem2 <= 12'(sod1 - SodW'(t1.hour) * SodW'(3600));
      t2    <= t1;

      doe3 <= 18'(z2 - DayW'(era2) * DayW'(EraDays));
      era3 <= era2;
      t3   <= t3_next;

      p1_4   <= 36'(doe3) * 36'(Recip1460);
      c36_4  <= c36_of(doe3);
      c146_4 <= (doe3 == 18'd146096);
      doe4   <= doe3;
      era4   <= era3;
      t4     <= t3;

      vv5  <= doe4 - 18'(p1_4[35:28]) + 18'(c36_4) - 18'(c146_4);
      doe5 <= doe4;
      era5 <= era4;
      t5   <= t4;

      p2_6 <= 38'(vv5) * 38'(Recip365);
      doe6 <= doe5;
      era6 <= era5;
      t6   <= t5;

      yoe7 <= yoe_c;
      dy7  <= 9'(doe6 - (18'(yoe_c) * 18'd365 + 18'(yoe_c[8:2]) - 18'(cent_of(yoe_c))));
      era7 <= era6;
      t7   <= t6;

      mday8 <= 5'(dy7 - month_start(mp_c) + 9'd1);
      mon8  <= (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
      yadj8 <= yoe7 + 9'(mp_c >= 4'd10);
      era8  <= era7;
      t8    <= t7;

      y9       <= 16'(yadj8) + 16'(era8) * 16'd400 - 16'(YearShift);
      leap9    <= leap_c;
      leapp9   <= is_leap(10'(yadj8) + 10'd399);
      yday9    <= days_before(mon8) + 9'(mday8) + 9'((mon8 > 4'd2) && leap_c);
      quarter9 <= quarter_of(mon8);
      mon9     <= mon8;
      mday9    <= mday8;
      t9       <= t8;

      sgnm10    <= ym1_c[15];
      sgn010    <= y9[15];
      pmil10    <= 28'(am1_c) * 28'd8389;
      pcen10    <= 27'(am1_c) * 27'd5243;
      pdec10    <= 30'(a0_c) * 30'd52429;
      wk10      <= wprod_c[16:11];
      j1_10     <= mod7(24'(t9.wday) + 24'd372 - 24'(yday9));
      y10       <= y9;
      leap10    <= leap9;
      leapp10   <= leapp9;
      yday10    <= yday9;
      quarter10 <= quarter9;
      mon10     <= mon9;
      mday10    <= mday9;
      t10       <= t9;

      field_value <= sel_c;
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    en && v10 && (t10.mode == MODE_HOUR) |=> field_value < 39'd24)
    else $error("hour out of range");
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    en && v10 && (t10.mode == MODE_MONTH) |=> field_value >= 39'd1 && field_value <= 39'd12)
    else $error("month out of range");
  a_week_range: assert property (@(posedge clk) disable iff (rst)
    en && v10 && (t10.mode == MODE_ISOWEEK) |=> field_value >= 39'd1 && field_value <= 39'd53)
    else $error("iso week out of range");
  a_dow_range: assert property (@(posedge clk) disable iff (rst)
    en && v10 && (t10.mode == MODE_DOW) |=> field_value >= 39'd1 && field_value <= 39'd7)
    else $error("day of week out of range");
`endif

endmodule

FILE: tb/sv/timestamp_calendar_field_extract_unit_tb.sv
// testbench for the timestamp calendar field extractor: predicted fields against the pipeline
`timescale 1ns / 100ps

module timestamp_calendar_field_extract_unit_tb;
  import tcfe_pkg::*;

  localparam longint MillisLo  = -64'sd62135596800000;
  localparam longint MillisHi  = 64'sd253402300799999;
  localparam longint DayMillis = 64'sd86400000;
  localparam int     StallLimit = 5000;

  logic clk;
  logic rst;

  tcfe_stamp_if stamp ();
  tcfe_field_if field ();

  timestamp_calendar_field_extract_unit i_dut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp),
    .field (field)
  );

  logic [FieldW-1:0] expected_fields[$];
  logic [ModeW-1:0]  expected_modes[$];
  longint            expected_millis[$];
  int error_count;
  int stamps_sent;
  int fields_seen;
  int quiet_cycles;
  bit send_idle_en;
  bit recv_idle_en;
  int recv_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
  endfunction

  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = (yy >= 0 ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic longint weekday_of(longint days);
    longint r;
    r = (days + 4) % 7;
    if (r < 0) r += 7;
    return r;
  endfunction

  function automatic longint iso_weeks(longint y);
    longint j1;
    j1 = weekday_of(day_number(y, 1, 1));
    if (j1 == 4 || (j1 == 3 && leap_year(y))) return 53;
    return 52;
  endfunction

  function automatic logic [FieldW-1:0] calc_field(longint ms, logic [ModeW-1:0] md);
    longint cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    longint secs, days, sod, z, era, doe, yoe, y, dy, mp, mday, mon, yday, wday, v, iso_wd, wk;
    secs = ms / 1000;
    days = secs / 86400;
    sod  = secs % 86400;
    if (sod < 0) begin
      sod += 86400;
      days -= 1;
    end
    z    = days + 719468;
    era  = (z >= 0 ? z : z - 146096) / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y    = yoe + era * 400;
    dy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * dy + 2) / 153;
    mday = dy - (153 * mp + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    if (mon <= 2) y += 1;
    yday = cum[mon-1] + mday;
    if (mon > 2 && leap_year(y)) yday += 1;
    wday = weekday_of(days);
    case (mode_t'(md))
      MODE_MILLENNIUM: v = (y - 1) / 1000 + 1;
      MODE_CENTURY:    v = (y - 1) / 100 + 1;
      MODE_DECADE:     v = y / 10;
      MODE_YEAR:       v = y;
      MODE_DOY:        v = yday;
      MODE_QUARTER:    v = (mon - 1) / 3 + 1;
      MODE_MONTH:      v = mon;
      MODE_ISOWEEK: begin
        iso_wd = (wday == 0) ? 7 : wday;
        wk = (yday - iso_wd + 10) / 7;
        if (wk < 1) wk = iso_weeks(y - 1);
        else if (wk > iso_weeks(y)) wk = 1;
        v = wk;
      end
      MODE_DOW:        v = wday + 1;
      MODE_DAY:        v = mday;
      MODE_HOUR:       v = sod / 3600;
      MODE_MINUTE:     v = (sod / 60) % 60;
      MODE_SECOND:     v = sod % 60;
      MODE_EPOCHSEC:   v = secs;
      default:         v = 0;
    endcase
    return v[FieldW-1:0];
  endfunction

  task automatic report_mismatch(longint ms, logic [ModeW-1:0] md, logic [FieldW-1:0] got,
                                 logic [FieldW-1:0] want);
    $display("mismatch: millis %0d mode %0d got %0d want %0d", ms, md,
             $signed(got), $signed(want));
    error_count++;
  endtask

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (stamp.valid && stamp.ready) begin
        expected_fields.push_back(calc_field(longint'(stamp.epoch_millis), stamp.mode));
        expected_modes.push_back(stamp.mode);
        expected_millis.push_back(longint'(stamp.epoch_millis));
        stamps_sent++;
      end
      if (field.valid && field.ready) begin
        fields_seen++;
        if (expected_fields.size() == 0) begin
          $display("unexpected field transfer, value %0d", field.field_value);
          error_count++;
        end else begin
          if (field.field_value !== expected_fields[0])
            report_mismatch(expected_millis[0], expected_modes[0], field.field_value,
                            expected_fields[0]);
          void'(expected_fields.pop_front());
          void'(expected_modes.pop_front());
          void'(expected_millis.pop_front());
        end
      end
      if ((stamp.valid && stamp.ready) || (field.valid && field.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random idle bursts and a requested long hold-off
  initial begin
    int idle_left;
    idle_left = 0;
    field.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold > 0) begin
        field.ready <= 1'b0;
        recv_hold--;
      end else if (idle_left > 0) begin
        field.ready <= 1'b0;
        idle_left--;
      end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
        field.ready <= 1'b0;
        idle_left = $urandom_range(1, 7) - 1;
      end else begin
        field.ready <= 1'b1;
      end
    end
  end

  task automatic send_stamp(longint ms, logic [ModeW-1:0] md);
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      stamp.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    stamp.valid        <= 1'b1;
    stamp.epoch_millis <= ms[MillisW-1:0];
    stamp.mode         <= md;
    do @(negedge clk); while (!stamp.ready);
    @(posedge clk);
  endtask

  function automatic longint rand_millis();
    longint unsigned r, span;
    longint d, y, off;
    case ($urandom_range(0, 4))
      0, 1: begin
        span = longint'(MillisHi - MillisLo + 1);
        r = {$urandom, $urandom};
        return MillisLo + longint'(r % span);
      end
      2, 3: begin
        y = $urandom_range(1, 9999);
        off = (y == 1) ? longint'($urandom_range(0, 4)) : longint'($urandom_range(0, 8)) - 4;
        d = day_number(y, 1, 1) + off;
        return d * DayMillis + longint'($urandom_range(0, 86399999));
      end
      default: begin
        r = {$urandom, $urandom};
        return longint'(r % 64'd20000000000) - 64'sd10000000000;
      end
    endcase
  endfunction

  task automatic run_random(int count);
    for (int k = 0; k < count; k++)
      send_stamp(rand_millis(), ModeW'($urandom_range(0, 15)));
  endtask

  task automatic drain();
    stamp.valid <= 1'b0;
    @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    longint picks[10];
    picks[0] = MillisLo;
    picks[1] = MillisHi;
    picks[2] = 0;
    picks[3] = -1;
    picks[4] = -1000;
    picks[5] = -1001;
    picks[6] = 999;
    picks[7] = day_number(2021, 1, 3) * DayMillis + 64'sd3723000;
    picks[8] = day_number(2020, 12, 31) * DayMillis;
    picks[9] = day_number(2000, 2, 29) * DayMillis - 1;
    for (int m = 0; m < 16; m++) send_stamp(picks[m % 10], ModeW'(m));
    for (int k = 0; k < 10; k++) send_stamp(picks[k], MODE_ISOWEEK);
    drain();
  endtask

  task automatic test_random_idle();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    run_random(500);
    drain();
  endtask

  task automatic test_backpressure();
    recv_hold = 300;
    run_random(150);
    drain();
  endtask

  task automatic test_full_rate();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    run_random(250);
    drain();
  endtask

  initial begin
    error_count  = 0;
    stamps_sent  = 0;
    fields_seen  = 0;
    quiet_cycles = 0;
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    recv_hold    = 0;
    rst = 1'b1;
    stamp.valid = 1'b0;
    stamp.epoch_millis = '0;
    stamp.mode = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_idle();
    test_backpressure();
    test_full_rate();
    repeat (60) @(posedge clk);
    $display("covered %0d stamps and %0d fields over all modes, boundary weeks,", stamps_sent,
             fields_seen);
    $display("pre-epoch times, idle bursts, a long receiver hold-off and full rate");
    if (error_count == 0 && expected_fields.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d fields outstanding", error_count, expected_fields.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
